// ===== src/mcbm_pkg.sv =====
package mcbm_pkg;

    localparam logic [15:0] ADDR_DECODE_MASK = 16'hE001;
    localparam logic [15:0] ADDR_OUTER       = 16'h6000;
    localparam logic [15:0] ADDR_CONTROL     = 16'h8000;
    localparam logic [15:0] ADDR_INNER       = 16'h8001;
    localparam logic [15:0] ADDR_UNLOCK      = 16'hA001;

    localparam logic [8:0] PRG_BANKS_RESET = 9'd32;

    localparam int CTRL_CHR_SWAP = 7;
    localparam int CTRL_PRG_SWAP = 6;
    localparam int UNLOCK_BIT    = 7;

    localparam logic [5:0] PRG_MASK_BITS = 6'h3F;
    localparam logic [3:0] CHR_LOW_BITS  = 4'hF;

    // Architectural mapper state, carried between the update logic and the top
    typedef struct packed {
        logic [7:0][7:0] inner;
        logic [7:0]      bank_control;
        logic            unlock;
        logic [1:0]      outer_idx;
        logic [3:0][7:0] outer;
        logic [7:0][8:0] chr;
        logic [3:0][7:0] prg;
    } mcbm_state_t;

endpackage

// ===== src/multicart_bank_mapper.sv =====
// An input transfer reaches its result on the m_ channel through the input register,
// then the update logic into the state and output registers.
// Throughput: one write per cycle; while a finished result waits on the output
// register the input register takes one more transfer, then s_ready drops.
// Reset (aresetn low, synchronous) clears all mapper registers, sets the
// program banks to 0, 1, 30, 31 and the bank count register to 32.
module multicart_bank_mapper
    import mcbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_cpu_address,
    input  logic [7:0]  s_write_data,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_chr_slot0_bank,
    output logic [8:0]  m_chr_slot1_bank,
    output logic [8:0]  m_chr_slot2_bank,
    output logic [8:0]  m_chr_slot3_bank,
    output logic [8:0]  m_chr_slot4_bank,
    output logic [8:0]  m_chr_slot5_bank,
    output logic [8:0]  m_chr_slot6_bank,
    output logic [8:0]  m_chr_slot7_bank,
    output logic [7:0]  m_prg_slot0_bank,
    output logic [7:0]  m_prg_slot1_bank,
    output logic [7:0]  m_prg_slot2_bank,
    output logic [7:0]  m_prg_slot3_bank
);

    logic [8:0]      prg_banks_reg;
    logic            in_valid_reg;
    logic [15:0]     in_addr_reg;
    logic [7:0]      in_data_reg;
    mcbm_state_t     state_reg;
    mcbm_state_t     state_next;
    mcbm_state_t     state_init;
    logic            out_valid_reg;
    logic [7:0][8:0] out_chr_reg;
    logic [3:0][7:0] out_prg_reg;
    logic            advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_comb begin
        state_init        = '0;
        state_init.prg[1] = 8'd1;
        state_init.prg[2] = 8'(PRG_BANKS_RESET - 9'd2);
        state_init.prg[3] = 8'(PRG_BANKS_RESET - 9'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_banks_reg <= PRG_BANKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            prg_banks_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_addr_reg <= s_cpu_address;
            in_data_reg <= s_write_data;
        end
    end

    mcbm_update u_update (
        .cur_state     (state_reg),
        .cpu_address   (in_addr_reg),
        .write_data    (in_data_reg),
        .prg_rom_banks (prg_banks_reg),
        .next_state    (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= state_init;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_chr_reg <= state_next.chr;
            out_prg_reg <= state_next.prg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_chr_slot0_bank = out_chr_reg[0];
    assign m_chr_slot1_bank = out_chr_reg[1];
    assign m_chr_slot2_bank = out_chr_reg[2];
    assign m_chr_slot3_bank = out_chr_reg[3];
    assign m_chr_slot4_bank = out_chr_reg[4];
    assign m_chr_slot5_bank = out_chr_reg[5];
    assign m_chr_slot6_bank = out_chr_reg[6];
    assign m_chr_slot7_bank = out_chr_reg[7];
    assign m_prg_slot0_bank = out_prg_reg[0];
    assign m_prg_slot1_bank = out_prg_reg[1];
    assign m_prg_slot2_bank = out_prg_reg[2];
    assign m_prg_slot3_bank = out_prg_reg[3];

    // An item leaving the input register must show up as a result
    a_advance_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced item did not reach the output register");

    // A held input item keeps its write until it moves on
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_addr_reg)
            && $stable(in_data_reg))
        else $error("held input item changed or was dropped");

    // Reset leaves both stages empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("pipeline not empty after reset");

    // State changes only when an item moves through the update logic
    a_state_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("mapper state changed without an item");

endmodule

// ===== src/mcbm_update.sv =====
module mcbm_update
    import mcbm_pkg::*;
(
    input  mcbm_state_t cur_state,
    input  logic [15:0] cpu_address,
    input  logic [7:0]  write_data,
    input  logic [8:0]  prg_rom_banks,
    output mcbm_state_t next_state
);

    mcbm_state_t upd;
    logic        do_recompute;
    logic [15:0] decoded;

    logic [5:0][7:0] c;
    logic [7:0]      chr_base;
    logic [7:0]      chr_mask;
    logic [7:0]      m;
    logic [7:0]      p0;
    logic [7:0]      p1;
    logic [7:0]      p2;
    logic [7:0]      p3;
    logic [8:0]      banks_m1;
    logic [8:0]      c0_inc;
    logic [8:0]      c1_inc;
    logic [3:0][8:0] pair_half;
    logic [3:0][8:0] quad_half;

    assign decoded = cpu_address & ADDR_DECODE_MASK;

    always_comb begin
        upd          = cur_state;
        do_recompute = 1'b0;
        unique case (decoded)
            ADDR_OUTER: begin
                if (cur_state.unlock) begin
                    upd.outer[cur_state.outer_idx] = write_data;
                    upd.outer_idx = cur_state.outer_idx + 2'd1;
                    do_recompute  = (cur_state.outer_idx == 2'd3);
                end
            end
            ADDR_CONTROL: begin
                upd.bank_control = write_data;
                do_recompute     = 1'b1;
            end
            ADDR_INNER: begin
                upd.inner[cur_state.bank_control[2:0]] = write_data;
                do_recompute = 1'b1;
            end
            ADDR_UNLOCK: begin
                if (write_data[UNLOCK_BIT]) begin
                    upd.unlock    = 1'b1;
                    upd.outer_idx = 2'd0;
                end else begin
                    upd.unlock = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Bank arithmetic on the updated registers
    assign chr_base = {upd.outer[1][3:0], 4'b0000};
    assign chr_mask = {upd.outer[2][3:0], CHR_LOW_BITS};

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            c[i] = (upd.inner[i] | chr_base) & chr_mask;
        end
    end

    assign c0_inc = {1'b0, c[0]} + 9'd1;
    assign c1_inc = {1'b0, c[1]} + 9'd1;

    assign pair_half[0] = {1'b0, c[0]};
    assign pair_half[1] = c0_inc;
    assign pair_half[2] = {1'b0, c[1]};
    assign pair_half[3] = c1_inc;
    assign quad_half[0] = {1'b0, c[2]};
    assign quad_half[1] = {1'b0, c[3]};
    assign quad_half[2] = {1'b0, c[4]};
    assign quad_half[3] = {1'b0, c[5]};

    assign m        = {2'b00, upd.outer[3][5:0] ^ PRG_MASK_BITS};
    assign p0       = (upd.inner[6] & m) | upd.outer[1];
    assign p1       = (upd.inner[7] & m) | upd.outer[1];
    assign p3       = m | upd.outer[1];
    assign banks_m1 = prg_rom_banks - 9'd1;
    assign p2       = p3 & banks_m1[7:0];

    always_comb begin
        next_state = upd;
        if (do_recompute) begin
            if (upd.bank_control[CTRL_CHR_SWAP]) begin
                next_state.chr[3:0] = quad_half;
                next_state.chr[7:4] = pair_half;
            end else begin
                next_state.chr[3:0] = pair_half;
                next_state.chr[7:4] = quad_half;
            end
            next_state.prg[0] = upd.bank_control[CTRL_PRG_SWAP] ? p2 : p0;
            next_state.prg[1] = p1;
            next_state.prg[2] = upd.bank_control[CTRL_PRG_SWAP] ? p0 : p2;
            next_state.prg[3] = p3;
        end
    end

endmodule
